@@ design/grid_maze_path_finder_defines.svh @@
// assertion macros shared by the checker of the maze path finder
`ifndef GRID_MAZE_PATH_FINDER_DEFINES_SVH
`define GRID_MAZE_PATH_FINDER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define GMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/gmp_pkg.sv @@
// shared types and constants of the maze path finder
package gmp_pkg;

	localparam int GRID_SIDE = 16;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int IDX_W     = $clog2(CELLS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int COORD_W   = 4;
	localparam int SIZE_W    = 5;

	localparam logic [1:0] MODE_WALL   = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WALL,
		OP_READ,
		OP_START,
		OP_CLR,
		OP_SEED,
		OP_POP,
		OP_CUR,
		OP_NREQ,
		OP_NCHK,
		OP_WINIT,
		OP_WREQ,
		OP_WSTEP,
		OP_FINIT,
		OP_FWR,
		OP_FSTEP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic oob;
		logic clr_last;
		logic q_empty;
		logic at_goal;
		logic at_start;
		logic dir_last;
	} status_t;

endpackage

@@ design/gmp_ctrl.sv @@
// sequencer of the maze path finder: search, walk-back and item handling
module gmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_mode,
	output logic              in_ready,
	input  logic              out_free,
	input  gmp_pkg::status_t  status,
	output gmp_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_CLR, ST_SEED, ST_POP, ST_CUR, ST_NREQ, ST_NCHK,
		ST_WINIT, ST_WREQ, ST_WSTEP, ST_FINIT, ST_FWR, ST_FSTEP, ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.op       = gmp_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		state_nx     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_DONE;
					case (in_mode)
						gmp_pkg::MODE_WALL: cmd.op = gmp_pkg::OP_WALL;
						gmp_pkg::MODE_READ: cmd.op = gmp_pkg::OP_READ;
						gmp_pkg::MODE_SEARCH: begin
							cmd.op   = gmp_pkg::OP_START;
							state_nx = ST_CHK;
						end
						default: cmd.op = gmp_pkg::OP_NONE;
					endcase
				end
			end
			ST_CHK: state_nx = status.oob ? ST_DONE : ST_CLR;
			ST_CLR: begin
				cmd.op = gmp_pkg::OP_CLR;
				if (status.clr_last) state_nx = ST_SEED;
			end
			ST_SEED: begin
				cmd.op   = gmp_pkg::OP_SEED;
				state_nx = ST_POP;
			end
			ST_POP: begin
				if (status.q_empty) begin
					state_nx = ST_DONE;
				end else begin
					cmd.op   = gmp_pkg::OP_POP;
					state_nx = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.op   = gmp_pkg::OP_CUR;
				state_nx = status.at_goal ? ST_WINIT : ST_NREQ;
			end
			ST_NREQ: begin
				cmd.op   = gmp_pkg::OP_NREQ;
				state_nx = ST_NCHK;
			end
			ST_NCHK: begin
				cmd.op   = gmp_pkg::OP_NCHK;
				state_nx = status.dir_last ? ST_POP : ST_NREQ;
			end
			ST_WINIT: begin
				cmd.op   = gmp_pkg::OP_WINIT;
				state_nx = ST_WREQ;
			end
			ST_WREQ: begin
				if (status.at_start) begin
					state_nx = ST_FINIT;
				end else begin
					cmd.op   = gmp_pkg::OP_WREQ;
					state_nx = ST_WSTEP;
				end
			end
			ST_WSTEP: begin
				cmd.op   = gmp_pkg::OP_WSTEP;
				state_nx = ST_WREQ;
			end
			ST_FINIT: begin
				cmd.op   = gmp_pkg::OP_FINIT;
				state_nx = ST_FWR;
			end
			ST_FWR: begin
				cmd.op   = gmp_pkg::OP_FWR;
				state_nx = status.at_start ? ST_DONE : ST_FSTEP;
			end
			ST_FSTEP: begin
				cmd.op   = gmp_pkg::OP_FSTEP;
				state_nx = ST_FWR;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ design/gmp_dp.sv @@
// datapath of the maze path finder: memories, queue pointers and walk-back
module gmp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gmp_pkg::cmd_t                       cmd,
	output gmp_pkg::status_t                    status,
	input  logic [gmp_pkg::SIZE_W-1:0]          maze_w,
	input  logic [gmp_pkg::SIZE_W-1:0]          maze_h,
	input  logic [gmp_pkg::COORD_W-1:0]         cell_col,
	input  logic [gmp_pkg::COORD_W-1:0]         cell_row,
	input  logic [3:0]                          wall_bits,
	input  logic [gmp_pkg::COORD_W-1:0]         start_col,
	input  logic [gmp_pkg::COORD_W-1:0]         start_row,
	input  logic [gmp_pkg::COORD_W-1:0]         end_col,
	input  logic [gmp_pkg::COORD_W-1:0]         end_row,
	input  logic [gmp_pkg::IDX_W-1:0]           path_index,
	output logic                                path_found,
	output logic [gmp_pkg::CNT_W-1:0]           path_length,
	output logic [gmp_pkg::COORD_W-1:0]         step_col,
	output logic [gmp_pkg::COORD_W-1:0]         step_row,
	output logic                                step_valid
);

	localparam int IW = gmp_pkg::IDX_W;
	localparam int CW = gmp_pkg::CNT_W;
	localparam int PW = gmp_pkg::COORD_W;
	localparam int SIZE_W_L = gmp_pkg::SIZE_W;

	logic [3:0]    wall_mem  [gmp_pkg::CELLS];
	logic          vis_mem   [gmp_pkg::CELLS];
	logic [1:0]    par_mem   [gmp_pkg::CELLS];
	logic [IW-1:0] queue_mem [gmp_pkg::CELLS];
	logic [IW-1:0] path_mem  [gmp_pkg::CELLS];

	logic [PW-1:0] sc_q, sr_q, ec_q, er_q;
	logic [CW-1:0] clr_q, head_q, tail_q, len_q, k_q, stored_len_q;
	logic          found_q;
	logic [IW-1:0] q_rd_q, cur_q, nb_q, walk_q, path_rd_q;
	logic [3:0]    wall_rd_q;
	logic          vis_rd_q, nb_ok_q, rd_flag_q, idx_ok_q;
	logic [1:0]    dir_q, par_rd_q;

	logic [SIZE_W_L-1:0] w_c, h_c;

	logic [IW-1:0] start_idx, goal_idx, nb_idx, prev_idx;
	logic [PW-1:0] cur_col, cur_row, walk_col, walk_row;
	logic          nb_in, take;

	// sizes of zero act as one, above the grid as the grid side
	always_comb begin
		w_c = maze_w;
		h_c = maze_h;
		if (maze_w == '0) w_c = SIZE_W_L'(1);
		else if (maze_w > SIZE_W_L'(gmp_pkg::GRID_SIDE)) w_c = SIZE_W_L'(gmp_pkg::GRID_SIDE);
		if (maze_h == '0) h_c = SIZE_W_L'(1);
		else if (maze_h > SIZE_W_L'(gmp_pkg::GRID_SIDE)) h_c = SIZE_W_L'(gmp_pkg::GRID_SIDE);
	end

	assign start_idx = {sr_q, sc_q};
	assign goal_idx  = {er_q, ec_q};
	assign cur_col   = cur_q[PW-1:0];
	assign cur_row   = cur_q[IW-1:PW];
	assign walk_col  = walk_q[PW-1:0];
	assign walk_row  = walk_q[IW-1:PW];

	// neighbour of the current cell in the direction under test
	always_comb begin
		nb_idx = cur_q;
		nb_in  = 1'b0;
		case (dir_q)
			gmp_pkg::DIR_UP: begin
				nb_idx = {cur_row - PW'(1), cur_col};
				nb_in  = (cur_row != '0);
			end
			gmp_pkg::DIR_RIGHT: begin
				nb_idx = {cur_row, cur_col + PW'(1)};
				nb_in  = ({1'b0, cur_col} + SIZE_W_L'(1)) < w_c;
			end
			gmp_pkg::DIR_DOWN: begin
				nb_idx = {cur_row + PW'(1), cur_col};
				nb_in  = ({1'b0, cur_row} + SIZE_W_L'(1)) < h_c;
			end
			default: begin
				nb_idx = {cur_row, cur_col - PW'(1)};
				nb_in  = (cur_col != '0);
			end
		endcase
	end

	// one step back along the parent direction
	always_comb begin
		case (par_rd_q)
			gmp_pkg::DIR_UP:    prev_idx = {walk_row + PW'(1), walk_col};
			gmp_pkg::DIR_RIGHT: prev_idx = {walk_row, walk_col - PW'(1)};
			gmp_pkg::DIR_DOWN:  prev_idx = {walk_row - PW'(1), walk_col};
			default:            prev_idx = {walk_row, walk_col + PW'(1)};
		endcase
	end

	assign take = nb_ok_q && !vis_rd_q && !wall_rd_q[dir_q];

	assign status.oob      = ({1'b0, sc_q} >= w_c) || ({1'b0, sr_q} >= h_c) ||
	                         ({1'b0, ec_q} >= w_c) || ({1'b0, er_q} >= h_c);
	assign status.clr_last = (clr_q[IW-1:0] == '1);
	assign status.q_empty  = (head_q >= tail_q);
	assign status.at_goal  = (q_rd_q == goal_idx);
	assign status.at_start = (walk_q == start_idx);
	assign status.dir_last = (dir_q == gmp_pkg::DIR_LEFT);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.op == gmp_pkg::OP_WALL) wall_mem[{cell_row, cell_col}] <= wall_bits;
		if (cmd.op == gmp_pkg::OP_CUR) wall_rd_q <= wall_mem[q_rd_q];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			gmp_pkg::OP_CLR:  vis_mem[clr_q[IW-1:0]] <= 1'b0;
			gmp_pkg::OP_SEED: vis_mem[start_idx] <= 1'b1;
			gmp_pkg::OP_NCHK: if (take) vis_mem[nb_q] <= 1'b1;
			default: ;
		endcase
		if (cmd.op == gmp_pkg::OP_NREQ) vis_rd_q <= vis_mem[nb_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gmp_pkg::OP_NCHK && take) par_mem[nb_q] <= dir_q;
		if (cmd.op == gmp_pkg::OP_WREQ || cmd.op == gmp_pkg::OP_FWR)
			par_rd_q <= par_mem[walk_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gmp_pkg::OP_SEED) queue_mem[0] <= start_idx;
		else if (cmd.op == gmp_pkg::OP_NCHK && take && tail_q < CW'(gmp_pkg::CELLS))
			queue_mem[tail_q[IW-1:0]] <= nb_q;
		if (cmd.op == gmp_pkg::OP_POP) q_rd_q <= queue_mem[head_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gmp_pkg::OP_FWR) path_mem[k_q[IW-1:0] - IW'(1)] <= walk_q;
		if (cmd.op == gmp_pkg::OP_READ) path_rd_q <= path_mem[path_index];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			gmp_pkg::OP_START: begin
				sc_q  <= start_col;
				sr_q  <= start_row;
				ec_q  <= end_col;
				er_q  <= end_row;
				clr_q <= '0;
			end
			gmp_pkg::OP_CLR:  clr_q <= clr_q + CW'(1);
			gmp_pkg::OP_SEED: begin
				head_q <= '0;
				tail_q <= CW'(1);
			end
			gmp_pkg::OP_POP: head_q <= head_q + CW'(1);
			gmp_pkg::OP_CUR: begin
				cur_q <= q_rd_q;
				dir_q <= gmp_pkg::DIR_UP;
			end
			gmp_pkg::OP_NREQ: begin
				nb_q    <= nb_idx;
				nb_ok_q <= nb_in;
			end
			gmp_pkg::OP_NCHK: begin
				dir_q <= dir_q + 2'd1;
				if (take && tail_q < CW'(gmp_pkg::CELLS)) tail_q <= tail_q + CW'(1);
			end
			gmp_pkg::OP_WINIT: begin
				walk_q <= goal_idx;
				len_q  <= CW'(1);
			end
			gmp_pkg::OP_WSTEP: begin
				walk_q <= prev_idx;
				len_q  <= len_q + CW'(1);
			end
			gmp_pkg::OP_FINIT: begin
				walk_q <= goal_idx;
				k_q    <= len_q;
			end
			gmp_pkg::OP_FSTEP: begin
				walk_q <= prev_idx;
				k_q    <= k_q - CW'(1);
			end
			default: ;
		endcase
	end

	// status of the last search and read flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			stored_len_q <= '0;
			rd_flag_q    <= 1'b0;
			idx_ok_q     <= 1'b0;
		end else begin
			if (cmd.op == gmp_pkg::OP_START) begin
				found_q      <= 1'b0;
				stored_len_q <= '0;
			end
			if (cmd.op == gmp_pkg::OP_FWR && walk_q == start_idx) begin
				found_q      <= 1'b1;
				stored_len_q <= len_q;
			end
			if (cmd.op == gmp_pkg::OP_READ) begin
				rd_flag_q <= 1'b1;
				idx_ok_q  <= ({1'b0, path_index} < stored_len_q);
			end else if (cmd.op == gmp_pkg::OP_WALL || cmd.op == gmp_pkg::OP_START ||
			             cmd.out_load) begin
				rd_flag_q <= 1'b0;
			end
		end
	end

	assign path_found  = found_q;
	assign path_length = stored_len_q;
	assign step_valid  = rd_flag_q && idx_ok_q;
	assign step_col    = step_valid ? path_rd_q[PW-1:0] : '0;
	assign step_row    = step_valid ? path_rd_q[IW-1:PW] : '0;

endmodule

@@ design/grid_maze_path_finder.sv @@
// top level of the grid maze shortest-path engine
// usage:
//  - apb port: reg 0 (byte 0) maze_width, reg 1 (byte 4) maze_height, 5 bits
//    each, reset 16; user writes only while the block is idle (not enforced)
//  - slave stream s_*: one item per command; mode 0 writes a cell's wall bits,
//    mode 1 runs a breadth-first search, mode 2 reads one cell of the stored
//    path, mode 3 only reports status
//  - master stream m_*: exactly one result item for every accepted item,
//    carrying the last search status and, for mode 2, the path cell read
//  - wall write, path read and status items go straight to the done state and
//    then to the output register; a search first clears the visited map, then
//    takes cells off the queue (one memory access a step, four neighbour
//    checks per cell), then walks back from the goal twice: once to count
//    the path length, once to store the path cells
//  - one item is in flight at a time; the next is taken as soon as the
//    sequencer is idle, even while the previous result waits in the output
//    register; a finished item waits in the done state for the output slot when stalled
//  - reset clears the sequencer, the output valid and the search status and
//    sets both sizes to 16; wall and path memories are undefined until written
module grid_maze_path_finder (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command items
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[1:0], cell_col[5:2], cell_row[9:6], wall_bits[13:10],
	// start_col[17:14], start_row[21:18], end_col[25:22], end_row[29:26],
	// path_index[37:30], zero[39:38]
	input  logic [39:0] s_tdata,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// path_found[0], path_length[9:1], step_col[13:10], step_row[17:14],
	// step_valid[18], zero[23:19]
	output logic [23:0] m_tdata
);

	logic [gmp_pkg::SIZE_W-1:0] width_q, height_q;
	logic                       out_valid_q;
	logic [18:0]                out_data_q;
	logic                       cfg_wr;

	gmp_pkg::cmd_t    cmd;
	gmp_pkg::status_t status;

	logic                         path_found, step_valid;
	logic [gmp_pkg::CNT_W-1:0]    path_length;
	logic [gmp_pkg::COORD_W-1:0]  step_col, step_row;

	// register file: the index is address bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {27'd0, height_q} : {27'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gmp_pkg::SIZE_W'(gmp_pkg::GRID_SIDE);
			height_q <= gmp_pkg::SIZE_W'(gmp_pkg::GRID_SIDE);
		end else if (cfg_wr) begin
			if (paddr[2]) height_q <= pwdata[gmp_pkg::SIZE_W-1:0];
			else          width_q  <= pwdata[gmp_pkg::SIZE_W-1:0];
		end
	end

	gmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tdata[1:0]),
		.in_ready (s_tready),
		.out_free (!out_valid_q || m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gmp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.maze_w      (width_q),
		.maze_h      (height_q),
		.cell_col    (s_tdata[5:2]),
		.cell_row    (s_tdata[9:6]),
		.wall_bits   (s_tdata[13:10]),
		.start_col   (s_tdata[17:14]),
		.start_row   (s_tdata[21:18]),
		.end_col     (s_tdata[25:22]),
		.end_row     (s_tdata[29:26]),
		.path_index  (s_tdata[37:30]),
		.path_found  (path_found),
		.path_length (path_length),
		.step_col    (step_col),
		.step_row    (step_row),
		.step_valid  (step_valid)
	);

	// output register: loaded when the item finishes and the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {step_valid, step_row, step_col, path_length, path_found};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_data_q};

endmodule

@@ design/gmp_checker.sv @@
// port-level checker of the maze path finder and its bind
`include "grid_maze_path_finder_defines.svh"

module gmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`GMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`GMP_ASSERT_NOW(a_len_found, m_tvalid, m_tdata[0] == (m_tdata[9:1] != 9'd0), "length disagrees with found")
	`GMP_ASSERT_NOW(a_step_found, m_tvalid && m_tdata[18], m_tdata[0], "valid step without a path")
	`GMP_ASSERT_NOW(a_step_zero, m_tvalid && !m_tdata[18], m_tdata[17:10] == 8'd0, "invalid step not zero")

endmodule

bind grid_maze_path_finder gmp_checker u_gmp_checker (.*);
